### rtl/core/integer_to_ascii_formatter_defines.svh
// Assertion macros shared by the integer to ASCII formatter checkers
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ITA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ita assertion failed");

// next-cycle implication, disabled during reset
`define ITA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ita assertion failed");

`endif

### rtl/core/ita_pkg.sv
// Types, constants and character helpers for the integer to ASCII formatter
`timescale 1ns / 1ps

package ita_pkg;

    localparam int MAX_WIDTH_DEF = 32;
    localparam int VALUE_W       = 32;
    localparam int DEC_DIGITS    = 10;
    localparam int NDIG_W        = $clog2(DEC_DIGITS + 1);
    localparam int BCD_W         = 4 * DEC_DIGITS;
    localparam int BIN_STEPS     = VALUE_W;
    localparam int CMD_W         = 2;
    localparam int MINW_W        = 6;
    localparam int CHAR_W        = 8;
    localparam int S_TDATA_W     = 40;

    localparam logic [CMD_W-1:0] CMD_DEC = 2'd0;

    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_SIGN,
        ST_EMIT
    } t_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic caps);
        logic [CHAR_W-1:0] base;
        if (d < 4'd10) begin
            base = CH_ZERO;
        end else begin
            base = caps ? (CH_UPPER_A - 8'd10) : (CH_LOWER_A - 8'd10);
        end
        return base + {4'b0, d};
    endfunction

endpackage

### rtl/core/integer_to_ascii_formatter.sv
// Integer to ASCII formatter: shift-and-add-3 converter with serial character output
//
//   channel   direction   payload
//   i_s_*     in          value, min_width, fill_zero in tdata; cmd in tuser
//   o_m_*     out         ascii_code in tdata; last character as tlast
//
// Decimal items pass through accept, the conversion steps and a count state; hex items
// skip the conversion steps; then the characters (sign included) go out one at a time.
// The 32 steps come from one add-3-and-shift unit reused once per value bit.
// Synchronous active-low reset clears the sequencer and the output valid.
// A stalled output holds its word; the sequencer waits for the slot to free.
`timescale 1ns / 1ps

module integer_to_ascii_formatter #(
    parameter int MAX_WIDTH = ita_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [ita_pkg::S_TDATA_W-1:0]  i_s_tdata,  // value[31:0], min_width[37:32], fill_zero[38]
    input  logic [ita_pkg::CMD_W-1:0]      i_s_tuser,  // cmd[1:0]
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [ita_pkg::CHAR_W-1:0]     o_m_tdata,  // ascii_code[7:0]
    output logic                           o_m_tlast
);
    import ita_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int SW = $clog2(BIN_STEPS);

    t_state              r_state, n_state;
    logic [VALUE_W-1:0]  r_bin, n_bin;
    logic [BCD_W-1:0]    r_bcd, n_bcd;
    logic [SW-1:0]       r_step, n_step;
    logic                r_neg, n_neg;
    logic                r_caps, n_caps;
    logic                r_pad, n_pad;
    logic [CW-1:0]       r_width, n_width;
    logic [NDIG_W-1:0]   r_ndig, n_ndig;
    logic [CW-1:0]       r_left, n_left;
    logic                r_ov, n_ov;
    logic [CHAR_W-1:0]   r_od, n_od;
    logic                r_olast, n_olast;

    logic [CMD_W-1:0]    in_cmd;
    logic [VALUE_W-1:0]  in_val;
    logic [MINW_W-1:0]   in_minw;
    logic                in_pad;
    logic                in_hex;
    logic                in_neg;
    logic [VALUE_W-1:0]  in_mag;
    logic [CW-1:0]       in_width;
    logic [BCD_W-1:0]    bcd_adj;
    logic [NDIG_W-1:0]   ndig;
    logic [CW-1:0]       ndig_ext;
    logic [CW-1:0]       pos;
    logic [CHAR_W-1:0]   emit_char;
    logic                slot_free;

    assign in_cmd  = i_s_tuser;
    assign in_val  = i_s_tdata[VALUE_W-1:0];
    assign in_minw = i_s_tdata[VALUE_W+MINW_W-1:VALUE_W];
    assign in_pad  = i_s_tdata[VALUE_W+MINW_W];
    assign in_hex  = (in_cmd != CMD_DEC);
    assign in_neg  = !in_hex && in_val[VALUE_W-1];
    assign in_mag  = in_neg ? (VALUE_W'(0) - in_val) : in_val;

    always_comb begin
        if (int'(in_minw) > MAX_WIDTH) begin
            in_width = CW'(MAX_WIDTH);
        end else begin
            in_width = CW'(in_minw);
        end
    end

    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_comb begin
        ndig = NDIG_W'(1);
        for (int i = 1; i < DEC_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                ndig = NDIG_W'(i + 1);
            end
        end
    end

    assign ndig_ext  = CW'(ndig);
    assign pos       = r_left - CW'(1);
    assign slot_free = !r_ov || i_m_tready;

    always_comb begin
        if (pos >= CW'(r_ndig)) begin
            emit_char = r_pad ? CH_ZERO : CH_SPACE;
        end else begin
            emit_char = digit_char(r_bcd[{pos[3:0], 2'b00} +: 4], r_caps);
        end
    end

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_step  = r_step;
        n_neg   = r_neg;
        n_caps  = r_caps;
        n_pad   = r_pad;
        n_width = r_width;
        n_ndig  = r_ndig;
        n_left  = r_left;
        n_ov    = r_ov && !i_m_tready;
        n_od    = r_od;
        n_olast = r_olast;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_neg   = in_neg;
                    n_caps  = in_cmd[1];
                    n_pad   = in_pad;
                    n_width = in_width;
                    n_step  = '0;
                    n_bin   = in_mag;
                    if (in_hex) begin
                        n_bcd   = BCD_W'(in_mag);
                        n_state = ST_COUNT;
                    end else begin
                        n_bcd   = '0;
                        n_state = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                n_bcd  = {bcd_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                n_bin  = {r_bin[VALUE_W-2:0], 1'b0};
                n_step = r_step + SW'(1);
                if (r_step == SW'(BIN_STEPS - 1)) begin
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: begin
                n_ndig  = ndig;
                n_left  = (ndig_ext > r_width) ? ndig_ext : r_width;
                n_state = r_neg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_od    = CH_MINUS;
                    n_olast = 1'b0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_od    = emit_char;
                    n_olast = (r_left == CW'(1));
                    n_left  = pos;
                    if (r_left == CW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin   <= n_bin;
        r_bcd   <= n_bcd;
        r_step  <= n_step;
        r_neg   <= n_neg;
        r_caps  <= n_caps;
        r_pad   <= n_pad;
        r_width <= n_width;
        r_ndig  <= n_ndig;
        r_left  <= n_left;
        r_od    <= n_od;
        r_olast <= n_olast;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;
    assign o_m_tlast  = r_olast;

endmodule

### rtl/core/ita_checker.sv
// Port-level checker for the integer to ASCII formatter, bound to the top level
`timescale 1ns / 1ps
`include "integer_to_ascii_formatter_defines.svh"

module ita_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           o_s_tready,
    input  logic [ita_pkg::S_TDATA_W-1:0]  i_s_tdata,  // value[31:0], min_width[37:32], fill_zero[38]
    input  logic [ita_pkg::CMD_W-1:0]      i_s_tuser,  // cmd[1:0]
    input  logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [ita_pkg::CHAR_W-1:0]     o_m_tdata,  // ascii_code[7:0]
    input  logic                           o_m_tlast
);
    import ita_pkg::*;

    logic in_word;
    logic out_hold;

    assign in_word  = i_s_tvalid && o_s_tready;
    assign out_hold = o_m_tvalid && !i_m_tready;

    `ITA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_hold,
                     o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
    `ITA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_word, !o_s_tready)
    `ITA_ASSERT_NOW(a_sign_not_last, i_clk, i_rst_n,
                    o_m_tvalid && (o_m_tdata == CH_MINUS), !o_m_tlast)
    `ITA_ASSERT_NOW(a_space_not_last, i_clk, i_rst_n,
                    o_m_tvalid && (o_m_tdata == CH_SPACE), !o_m_tlast)

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (.*);
